### rtl/plsh_pkg.sv
// ----------------------------------------------------------------------------
// plsh_pkg
// Shared widths, constants, types and helpers for the luma, saturation and
// hue adjustment pipeline.
// ----------------------------------------------------------------------------
package plsh_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    localparam int Y16W = 24;   // luma, Q.16, unsigned
    localparam int XW   = 28;   // CORDIC vector, Q.16, signed
    localparam int ZW   = 25;   // CORDIC angle, degrees Q.16, signed
    localparam int PW   = XW + 13;  // vector times saturation gain
    localparam int CPW  = PW + 17;  // times inverse CORDIC gain
    localparam int C24W = CPW - 16; // color difference, Q.24
    localparam int L24W = 36;   // scaled luma, Q.24, unsigned
    localparam int GSW  = 62;   // green sum, Q.40

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_OFS   = 2'd2;

    localparam logic [11:0] LUMA_GAIN_RST = 12'd256;
    localparam logic [11:0] SAT_GAIN_RST  = 12'd256;

    localparam logic signed [16:0] INV_K         = 17'sd39797;
    localparam logic signed [16:0] G_FROM_CR     = 17'sd33382;
    localparam logic signed [16:0] G_FROM_CB     = 17'sd12728;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [Y16W-1:0]      y16;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] a;
        unique case (idx)
            0: a = 25'sd2949120;  1: a = 25'sd1740967; 2: a = 25'sd919879;
            3: a = 25'sd466945;   4: a = 25'sd234379;  5: a = 25'sd117304;
            6: a = 25'sd58666;    7: a = 25'sd29335;   8: a = 25'sd14668;
            9: a = 25'sd7334;     10: a = 25'sd3667;   11: a = 25'sd1833;
            12: a = 25'sd917;     13: a = 25'sd458;    14: a = 25'sd229;
            15: a = 25'sd115;     16: a = 25'sd57;     17: a = 25'sd29;
            18: a = 25'sd14;      19: a = 25'sd7;      20: a = 25'sd4;
            21: a = 25'sd2;       22: a = 25'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Non-positive values give 0; otherwise drop the fraction and limit to 255.
    function automatic logic [7:0] to_channel(input logic signed [GSW-1:0] v,
                                              input int frac);
        logic signed [GSW-1:0] w;
        w = v >>> frac;
        if (v <= 0) begin
            return 8'd0;
        end
        if (w > 255) begin
            return 8'd255;
        end
        return w[7:0];
    endfunction

endpackage

### rtl/plsh_front.sv
// ----------------------------------------------------------------------------
// plsh_front
// Splits the pixel into luma and color differences and folds the hue offset
// into the CORDIC's range of plus or minus 90 degrees.
// ----------------------------------------------------------------------------
module plsh_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic signed [9:0]     hue_ofs,
    output logic                  out_vld,
    output plsh_pkg::cordic_t     out_data
);
    import plsh_pkg::*;

    logic                   vld_reg;
    cordic_t                data_reg, data_next;
    logic [Y16W-1:0]        y16;
    logic signed [XW-1:0]   cb, cr;
    logic signed [10:0]     a1, a2;
    logic                   flip;

    always_comb begin
        y16 = Y16W'(red) * Y16W'(19595) + Y16W'(green) * Y16W'(38470)
            + Y16W'(blue) * Y16W'(7471);
        cb = XW'($signed({1'b0, blue, 16'd0})) - XW'($signed({1'b0, y16}));
        cr = XW'($signed({1'b0, red, 16'd0})) - XW'($signed({1'b0, y16}));

        a1 = 11'(hue_ofs);
        if (a1 >= 11'sd180) begin
            a1 = a1 - 11'sd360;
        end else if (a1 < -11'sd180) begin
            a1 = a1 + 11'sd360;
        end
        flip = 1'b0;
        a2 = a1;
        if (a1 > 11'sd90) begin
            flip = 1'b1;
            a2 = a1 - 11'sd180;
        end else if (a1 < -11'sd90) begin
            flip = 1'b1;
            a2 = a1 + 11'sd180;
        end

        data_next.x   = flip ? -cb : cb;
        data_next.y   = flip ? -cr : cr;
        data_next.z   = ZW'(a2) <<< 16;
        data_next.y16 = y16;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

### rtl/plsh_cordic.sv
// ----------------------------------------------------------------------------
// plsh_cordic
// Rotation-mode CORDIC, one registered stage per step.
// ----------------------------------------------------------------------------
module plsh_cordic (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  plsh_pkg::cordic_t     in_data,
    output logic                  out_vld,
    output plsh_pkg::cordic_t     out_data
);
    import plsh_pkg::*;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic    vld_cur;
        cordic_t st_cur;
        cordic_t st_next;
        logic    vld_reg;
        cordic_t st_reg;

        if (i == 0) begin : g_first
            assign vld_cur = in_vld;
            assign st_cur  = in_data;
        end else begin : g_rest
            assign vld_cur = g_step[i-1].vld_reg;
            assign st_cur  = g_step[i-1].st_reg;
        end

        always_comb begin
            st_next.y16 = st_cur.y16;
            if (st_cur.z >= 0) begin
                st_next.x = st_cur.x - (st_cur.y >>> i);
                st_next.y = st_cur.y + (st_cur.x >>> i);
                st_next.z = st_cur.z - atan_deg(i);
            end else begin
                st_next.x = st_cur.x + (st_cur.y >>> i);
                st_next.y = st_cur.y - (st_cur.x >>> i);
                st_next.z = st_cur.z + atan_deg(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_cur;
            end
            if (en) begin
                st_reg <= st_next;
            end
        end
    end

    assign out_vld  = g_step[STEPS-1].vld_reg;
    assign out_data = g_step[STEPS-1].st_reg;

    // The folded start angle never leaves plus or minus 90 degrees.
    a_start_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld |-> (in_data.z <= ZW'(90 * 65536) && in_data.z >= -ZW'(90 * 65536)))
        else $error("CORDIC start angle out of range");

    // Reset empties the rotator, so no item is valid at its end afterwards.
    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !out_vld)
        else $error("CORDIC valid not cleared by reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(out_vld))
        else $error("CORDIC valid moved while stalled");

endmodule

### rtl/plsh_back.sv
// ----------------------------------------------------------------------------
// plsh_back
// Gain scaling, CORDIC gain removal, conversion back to RGB and clamping.
// ----------------------------------------------------------------------------
module plsh_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  plsh_pkg::cordic_t     in_data,
    input  logic [11:0]           luma_gain,
    input  logic [11:0]           sat_gain,
    output logic                  out_vld,
    output logic [23:0]           out_pix
);
    import plsh_pkg::*;

    // Stage A: gain products.
    logic                   a_vld_reg;
    logic signed [PW-1:0]   a_px_reg, a_py_reg;
    logic [L24W-1:0]        a_l24_reg;
    // Stage B: color differences in Q.24.
    logic                   b_vld_reg;
    logic signed [C24W-1:0] b_cb_reg, b_cr_reg;
    logic [L24W-1:0]        b_l24_reg;
    logic signed [CPW-1:0]  pcb, pcr;
    // Stage C: green products and red/blue sums.
    logic                   c_vld_reg;
    logic signed [GSW-1:0]  c_gcr_reg, c_gcb_reg, c_rs_reg, c_bs_reg, c_l_reg;
    // Stage D: output register.
    logic                   d_vld_reg;
    logic [23:0]            d_pix_reg;
    logic signed [GSW-1:0]  g_sum;

    assign pcb = CPW'(a_px_reg) * CPW'(INV_K);
    assign pcr = CPW'(a_py_reg) * CPW'(INV_K);
    assign g_sum = (c_l_reg <<< 16) - c_gcr_reg - c_gcb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
        if (en) begin
            a_px_reg  <= PW'(in_data.x) * PW'($signed({1'b0, sat_gain}));
            a_py_reg  <= PW'(in_data.y) * PW'($signed({1'b0, sat_gain}));
            a_l24_reg <= L24W'(in_data.y16) * L24W'(luma_gain);

            // Black luma forces the color difference to zero.
            b_cb_reg  <= (a_l24_reg == '0) ? '0 : C24W'(pcb >>> 16);
            b_cr_reg  <= (a_l24_reg == '0) ? '0 : C24W'(pcr >>> 16);
            b_l24_reg <= a_l24_reg;

            c_gcr_reg <= GSW'(b_cr_reg) * GSW'(G_FROM_CR);
            c_gcb_reg <= GSW'(b_cb_reg) * GSW'(G_FROM_CB);
            c_l_reg   <= GSW'($signed({1'b0, b_l24_reg}));
            c_rs_reg  <= GSW'($signed({1'b0, b_l24_reg})) + GSW'(b_cr_reg);
            c_bs_reg  <= GSW'($signed({1'b0, b_l24_reg})) + GSW'(b_cb_reg);

            d_pix_reg <= {to_channel(c_bs_reg, 24), to_channel(g_sum, 40),
                          to_channel(c_rs_reg, 24)};
        end
    end

    assign out_vld = d_vld_reg;
    assign out_pix = d_pix_reg;

    a_zero_luma: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_vld_reg && b_l24_reg == '0) |-> (b_cb_reg == '0 && b_cr_reg == '0))
        else $error("color difference not cleared for zero luma");

    a_black_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && c_vld_reg && c_l_reg == '0) |=> (d_pix_reg == '0))
        else $error("zero luma did not give a black pixel");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(d_vld_reg) && $stable(c_vld_reg) && $stable(a_vld_reg)))
        else $error("pipeline valid moved while stalled");

endmodule

### rtl/pixel_luma_sat_hue_adjust.sv
// ----------------------------------------------------------------------------
// pixel_luma_sat_hue_adjust
// Luma gain, saturation gain and hue rotation of an RGB888 pixel stream.
// ----------------------------------------------------------------------------
// One pixel enters per clock while the output is not stalled; it passes the
// front end register, the one-stage-per-step CORDIC rotator and the four
// multiply and clamp stages, in that order, before it leaves.
// The whole pipeline advances together, so it stops only while a finished
// pixel waits at the output. Registers must be written through cfg_we only
// while no pixels are in flight; the block itself does not enforce this.
module pixel_luma_sat_hue_adjust (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [plsh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [plsh_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,  // red_in, green_in, blue_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata   // red_out, green_out, blue_out
);
    import plsh_pkg::*;

    logic [11:0]       luma_gain_reg, sat_gain_reg;
    logic signed [9:0] hue_ofs_reg;
    logic              en;
    logic              f_vld, c_vld;
    cordic_t           f_data, c_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_gain_reg <= LUMA_GAIN_RST;
            sat_gain_reg  <= SAT_GAIN_RST;
            hue_ofs_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LUMA_GAIN: luma_gain_reg <= cfg_wdata;
                CFG_SAT_GAIN:  sat_gain_reg  <= cfg_wdata;
                CFG_HUE_OFS:   hue_ofs_reg   <= $signed(cfg_wdata[9:0]);
                default: ;
            endcase
        end
    end

    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    plsh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_tvalid),
        .red      (s_tdata[7:0]),
        .green    (s_tdata[15:8]),
        .blue     (s_tdata[23:16]),
        .hue_ofs  (hue_ofs_reg),
        .out_vld  (f_vld),
        .out_data (f_data)
    );

    plsh_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (f_vld),
        .in_data  (f_data),
        .out_vld  (c_vld),
        .out_data (c_data)
    );

    plsh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (c_vld),
        .in_data   (c_data),
        .luma_gain (luma_gain_reg),
        .sat_gain  (sat_gain_reg),
        .out_vld   (m_tvalid),
        .out_pix   (m_tdata)
    );

endmodule
